// ===== rtl/hte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types and constants of the homography transfer error block.
// ----------------------------------------------------------------------------
package hte_pkg;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  localparam int NUM_COEF   = 9;
  localparam int IDX_W      = 4;
  localparam int FRAC_W     = 16;
  localparam int SLICE_W    = 16;
  localparam int QUOT_W     = 63;
  localparam int DIST_W     = 32;
  localparam int SQRT_STEPS = 32;

  localparam logic [QUOT_W-1:0] PROJ_CLAMP = 63'h4000_0000_0000_0000;
  localparam logic [DIST_W-1:0] DIST_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    B_IDLE,
    B_TERM,
    B_MUL,
    B_ADD,
    B_ACC,
    B_CHECK,
    B_DSTART,
    B_DIV,
    B_DDONE,
    B_DIFF,
    B_SQ,
    B_SQ2,
    B_SUM,
    B_SQRT,
    B_OUT
  } back_state_t;

endpackage

// ===== rtl/hte_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_front
// Takes input items, drops loads aimed past the matrix and packs the rest
// into one word for the queue.
// ----------------------------------------------------------------------------
module hte_front #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 48,
  parameter int DW          = 1 + hte_pkg::IDX_W + COEF_WIDTH + 4 * COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid,
  output logic                          stall,
  input  logic                          kind,
  input  logic [hte_pkg::IDX_W-1:0]     coef_index,
  input  logic signed [COEF_WIDTH-1:0]  coef_value,
  input  logic signed [COORD_WIDTH-1:0] src_x,
  input  logic signed [COORD_WIDTH-1:0] src_y,
  input  logic signed [COORD_WIDTH-1:0] dst_x,
  input  logic signed [COORD_WIDTH-1:0] dst_y,
  output logic                          fwd_valid,
  output logic [DW-1:0]                 fwd_data,
  input  logic                          fwd_full
);

  logic keep;

  assign keep  = (kind == hte_pkg::KIND_POINT) ||
                 (coef_index < hte_pkg::IDX_W'(hte_pkg::NUM_COEF));
  assign stall = fwd_valid && fwd_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (!stall) begin
      fwd_valid <= valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && valid) begin
      fwd_data <= {kind, coef_index, coef_value, src_x, src_y, dst_x, dst_y};
    end
  end

endmodule

// ===== rtl/hte_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module hte_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          out_valid,
  output logic [DW-1:0] out_data
);

  logic [DW-1:0] mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/hte_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_back
// Holds the matrix, forms X, Y, W with a sliced multiplier, divides by W
// with a restoring divider and takes the distance with a digit square root.
// ----------------------------------------------------------------------------
module hte_back #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 48,
  parameter int DW          = 1 + hte_pkg::IDX_W + COEF_WIDTH + 4 * COORD_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  logic [DW-1:0]                q_data,
  output logic                         pop,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [hte_pkg::DIST_W-1:0]   distance,
  output logic                         projection_invalid
);

  localparam int C      = COEF_WIDTH;
  localparam int K      = COORD_WIDTH;
  localparam int S      = (K + hte_pkg::SLICE_W - 1) / hte_pkg::SLICE_W;
  localparam int SLW    = (S > 1) ? $clog2(S) : 1;
  localparam int PW     = C + S * hte_pkg::SLICE_W;
  localparam int ACC_W  = C + K + 1;
  localparam int NUM_W  = ACC_W + hte_pkg::FRAC_W;
  localparam int QW     = hte_pkg::QUOT_W;

  hte_pkg::back_state_t state, state_next;

  logic signed [C-1:0]       coef [hte_pkg::NUM_COEF];
  logic signed [K-1:0]       sx, sy, ax, ay;
  logic [1:0]                r, c;
  logic [SLW-1:0]            sl;
  logic [C-1:0]              mc;
  logic [S*hte_pkg::SLICE_W-1:0] mk;
  logic                      neg;
  logic [C+hte_pkg::SLICE_W-1:0] pp;
  logic [C+K-1:0]            prod;
  logic signed [ACC_W-1:0]   acc [3];
  logic                      dsel;
  logic                      qneg;
  logic [ACC_W-1:0]          rem;
  logic [QW-1:0]             numlo;
  logic [QW-1:0]             quo;
  logic [5:0]                cnt;
  logic signed [63:0]        pval;
  logic [63:0]               ux, uy;
  logic [63:0]               sqa, sqb;
  logic [63:0]               srem, sres, sbit;
  logic [4:0]                scnt;
  logic [hte_pkg::DIST_W-1:0] dist_r;
  logic                      inv_r;
  logic                      out_load;

  // unpacked queue word
  logic                      q_kind;
  logic [hte_pkg::IDX_W-1:0] q_idx;
  logic signed [C-1:0]       q_value;

  assign q_kind  = q_data[DW-1];
  assign q_idx   = q_data[DW-2 -: hte_pkg::IDX_W];
  assign q_value = q_data[DW-2-hte_pkg::IDX_W -: C];

  // operand selection
  logic [hte_pkg::IDX_W-1:0] coef_addr;
  logic signed [C-1:0]       cur_coef;
  logic [C-1:0]              coef_mag;
  logic signed [K-1:0]       cur_coord;
  logic [K-1:0]              coord_mag;
  logic [C+hte_pkg::SLICE_W-1:0] pp_full;
  logic [PW-1:0]             pp_shift;
  logic [ACC_W-1:0]          prod_ext;
  logic [ACC_W-1:0]          term;

  assign coef_addr = {2'b00, r} + {1'b0, r, 1'b0} + {2'b00, c};
  assign cur_coef  = coef[coef_addr];
  assign coef_mag  = cur_coef[C-1] ? (~cur_coef + 1'b1) : cur_coef;
  assign cur_coord = (c == 2'd0) ? sx : sy;
  assign coord_mag = cur_coord[K-1] ? (~cur_coord + 1'b1) : cur_coord;
  assign pp_full   = (C + hte_pkg::SLICE_W)'(mc) *
                     (C + hte_pkg::SLICE_W)'(mk[sl*hte_pkg::SLICE_W +: hte_pkg::SLICE_W]);
  assign pp_shift  = PW'(pp) << (sl * hte_pkg::SLICE_W);
  assign prod_ext  = ACC_W'(prod);
  assign term      = neg ? (~prod_ext + 1'b1) : prod_ext;

  // divider
  logic signed [ACC_W-1:0]   sel_acc;
  logic [ACC_W-1:0]          num_mag;
  logic [ACC_W-1:0]          den_mag;
  logic [NUM_W-1:0]          num;
  logic [ACC_W-1:0]          num_hi;
  logic                      div_ovf;
  logic [ACC_W:0]            rem2;
  logic                      rem_ge;
  logic [QW-1:0]             qclamp;
  logic signed [K-1:0]       dst_coord;
  logic signed [63:0]        diff;

  assign sel_acc = dsel ? acc[1] : acc[0];
  assign num_mag = sel_acc[ACC_W-1] ? (~sel_acc + 1'b1) : sel_acc;
  assign den_mag = acc[2][ACC_W-1] ? (~acc[2] + 1'b1) : acc[2];
  assign num     = {num_mag, {hte_pkg::FRAC_W{1'b0}}};
  assign num_hi  = ACC_W'(num[NUM_W-1:QW]);
  assign div_ovf = (num_hi >= den_mag);
  assign rem2    = {rem, numlo[QW-1]};
  assign rem_ge  = (rem2 >= {1'b0, den_mag});
  assign qclamp  = (quo > hte_pkg::PROJ_CLAMP) ? hte_pkg::PROJ_CLAMP : quo;
  assign dst_coord = dsel ? ay : ax;
  assign diff    = pval - 64'(dst_coord);

  // squares and root
  logic [31:0] sq_op;
  logic [63:0] sq;
  logic [64:0] sq_sum;
  logic        sq_ovf;
  logic [63:0] trial;
  logic        root_ge;
  logic [63:0] sres_nx;

  assign sq_op   = (state == hte_pkg::B_SQ) ? ux[31:0] : uy[31:0];
  assign sq      = 64'(sq_op) * 64'(sq_op);
  assign sq_sum  = {1'b0, sqa} + {1'b0, sqb};
  assign sq_ovf  = (ux[63:32] != 32'd0) || (uy[63:32] != 32'd0);
  assign trial   = sres + sbit;
  assign root_ge = (srem >= trial);
  assign sres_nx = root_ge ? ((sres >> 1) + sbit) : (sres >> 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hte_pkg::B_IDLE: begin
        if (q_valid && q_kind == hte_pkg::KIND_POINT) begin
          state_next = hte_pkg::B_TERM;
        end
      end
      hte_pkg::B_TERM: begin
        state_next = (c == 2'd2) ? hte_pkg::B_ACC : hte_pkg::B_MUL;
      end
      hte_pkg::B_MUL: state_next = hte_pkg::B_ADD;
      hte_pkg::B_ADD: begin
        state_next = (sl == SLW'(S - 1)) ? hte_pkg::B_ACC : hte_pkg::B_MUL;
      end
      hte_pkg::B_ACC: begin
        if (c == 2'd2 && r == 2'd2) begin
          state_next = hte_pkg::B_CHECK;
        end else begin
          state_next = hte_pkg::B_TERM;
        end
      end
      hte_pkg::B_CHECK: begin
        state_next = (acc[2] == '0) ? hte_pkg::B_OUT : hte_pkg::B_DSTART;
      end
      hte_pkg::B_DSTART: state_next = div_ovf ? hte_pkg::B_DDONE : hte_pkg::B_DIV;
      hte_pkg::B_DIV: begin
        if (cnt == 6'(QW - 1)) begin
          state_next = hte_pkg::B_DDONE;
        end
      end
      hte_pkg::B_DDONE: state_next = hte_pkg::B_DIFF;
      hte_pkg::B_DIFF: state_next = dsel ? hte_pkg::B_SQ : hte_pkg::B_DSTART;
      hte_pkg::B_SQ: state_next = sq_ovf ? hte_pkg::B_OUT : hte_pkg::B_SQ2;
      hte_pkg::B_SQ2: state_next = hte_pkg::B_SUM;
      hte_pkg::B_SUM: state_next = sq_sum[64] ? hte_pkg::B_OUT : hte_pkg::B_SQRT;
      hte_pkg::B_SQRT: begin
        if (scnt == 5'(hte_pkg::SQRT_STEPS - 1)) begin
          state_next = hte_pkg::B_OUT;
        end
      end
      hte_pkg::B_OUT: begin
        if (!result_valid || !result_stall) begin
          state_next = hte_pkg::B_IDLE;
        end
      end
      default: state_next = hte_pkg::B_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state)
      hte_pkg::B_IDLE: pop = q_valid;
      hte_pkg::B_OUT:  out_load = !result_valid || !result_stall;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= hte_pkg::B_IDLE;
      result_valid <= 1'b0;
      for (int i = 0; i < hte_pkg::NUM_COEF; i++) begin
        coef[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (pop && q_kind == hte_pkg::KIND_LOAD) begin
        coef[q_idx] <= q_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      distance           <= dist_r;
      projection_invalid <= inv_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      hte_pkg::B_IDLE: begin
        sx <= q_data[4*K-1 -: K];
        sy <= q_data[3*K-1 -: K];
        ax <= q_data[2*K-1 -: K];
        ay <= q_data[K-1:0];
        r  <= 2'd0;
        c  <= 2'd0;
        for (int i = 0; i < 3; i++) begin
          acc[i] <= '0;
        end
      end
      hte_pkg::B_TERM: begin
        mc <= coef_mag;
        mk <= (S * hte_pkg::SLICE_W)'(coord_mag);
        sl <= '0;
        if (c == 2'd2) begin
          neg  <= cur_coef[C-1];
          prod <= (C + K)'({coef_mag, {hte_pkg::FRAC_W{1'b0}}});
        end else begin
          neg  <= cur_coef[C-1] ^ cur_coord[K-1];
          prod <= '0;
        end
      end
      hte_pkg::B_MUL: pp <= pp_full;
      hte_pkg::B_ADD: begin
        prod <= prod + pp_shift[C+K-1:0];
        sl   <= sl + 1'b1;
      end
      hte_pkg::B_ACC: begin
        acc[r] <= acc[r] + term;
        if (c == 2'd2) begin
          c <= 2'd0;
          r <= r + 2'd1;
        end else begin
          c <= c + 2'd1;
        end
      end
      hte_pkg::B_CHECK: begin
        dsel   <= 1'b0;
        dist_r <= hte_pkg::DIST_MAX;
        inv_r  <= 1'b1;
      end
      hte_pkg::B_DSTART: begin
        qneg  <= sel_acc[ACC_W-1] ^ acc[2][ACC_W-1];
        rem   <= num_hi;
        numlo <= num[QW-1:0];
        cnt   <= '0;
        if (div_ovf) begin
          quo <= hte_pkg::PROJ_CLAMP;
        end else begin
          quo <= '0;
        end
      end
      hte_pkg::B_DIV: begin
        rem   <= rem_ge ? ACC_W'(rem2 - {1'b0, den_mag}) : rem2[ACC_W-1:0];
        quo   <= {quo[QW-2:0], rem_ge};
        numlo <= numlo << 1;
        cnt   <= cnt + 6'd1;
      end
      hte_pkg::B_DDONE: begin
        pval <= qneg ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
      end
      hte_pkg::B_DIFF: begin
        if (dsel) begin
          uy <= diff[63] ? (~diff + 1'b1) : diff;
        end else begin
          ux <= diff[63] ? (~diff + 1'b1) : diff;
        end
        dsel <= 1'b1;
      end
      hte_pkg::B_SQ: begin
        sqa    <= sq;
        dist_r <= hte_pkg::DIST_MAX;
        inv_r  <= 1'b0;
      end
      hte_pkg::B_SQ2: sqb <= sq;
      hte_pkg::B_SUM: begin
        srem <= sq_sum[63:0];
        sres <= '0;
        sbit <= 64'h4000_0000_0000_0000;
        scnt <= '0;
      end
      hte_pkg::B_SQRT: begin
        if (root_ge) begin
          srem <= srem - trial;
        end
        sres <= sres_nx;
        sbit <= sbit >> 2;
        scnt <= scnt + 5'd1;
        dist_r <= sres_nx[hte_pkg::DIST_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/homography_transfer_error.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homography_transfer_error
// Transfer error of a point pair through a loaded 3x3 homography.
// ----------------------------------------------------------------------------
// Load items (kind 0) write one coefficient of the row-major matrix and give
// no result; a load with an index above 8 is dropped. Point items (kind 1)
// give one result each: the saturated Q16.16 distance from the target point
// to the projected source point, or all ones with projection_invalid set when
// the projected w is zero. Items pass a two-entry queue, so the front keeps
// taking items while the back works, until the queue is full. A load is
// written into the matrix when the back pops it. A point takes, per matrix
// row, S slice multiplies (S = COORD_WIDTH/16 rounded up, 16 bits each) per
// coordinate term, two divisions by w at one quotient bit a cycle and a
// 32-step square root; at default widths the divider takes most of the time.
module homography_transfer_error #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          kind,
  input  logic [3:0]                    coef_index,
  input  logic signed [COEF_WIDTH-1:0]  coef_value,
  input  logic signed [COORD_WIDTH-1:0] src_x,
  input  logic signed [COORD_WIDTH-1:0] src_y,
  input  logic signed [COORD_WIDTH-1:0] dst_x,
  input  logic signed [COORD_WIDTH-1:0] dst_y,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [31:0]                   distance,
  output logic                          projection_invalid
);

  localparam int DW = 1 + hte_pkg::IDX_W + COEF_WIDTH + 4 * COORD_WIDTH;

  logic          fwd_valid;
  logic [DW-1:0] fwd_data;
  logic          q_full;
  logic          q_valid;
  logic [DW-1:0] q_data;
  logic          q_pop;

  hte_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH),
    .DW         (DW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .valid     (item_valid),
    .stall     (item_stall),
    .kind      (kind),
    .coef_index(coef_index),
    .coef_value(coef_value),
    .src_x     (src_x),
    .src_y     (src_y),
    .dst_x     (dst_x),
    .dst_y     (dst_y),
    .fwd_valid (fwd_valid),
    .fwd_data  (fwd_data),
    .fwd_full  (q_full)
  );

  hte_queue #(
    .DW(DW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fwd_valid),
    .push_data(fwd_data),
    .full     (q_full),
    .pop      (q_pop),
    .out_valid(q_valid),
    .out_data (q_data)
  );

  hte_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH),
    .DW         (DW)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .pop               (q_pop),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .distance          (distance),
    .projection_invalid(projection_invalid)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("back took from an empty queue");

  a_entry_held: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_pop) |=> q_valid)
    else $error("queue entry lost before transfer to the back");

  a_invalid_saturates: assert property (@(posedge clk) disable iff (rst)
    (result_valid && projection_invalid) |-> (distance == 32'hFFFF_FFFF))
    else $error("invalid projection without saturated distance");

endmodule
